>>> rtl/hmmr_pkg.sv
package hmmr_pkg;

	localparam int unsigned SAMPLE_W   = 8;
	localparam int unsigned INDEX_W    = 16;
	localparam int unsigned LEVEL_W    = 2;
	localparam int unsigned SPG_W      = 11;
	localparam int unsigned GPR_W      = 9;
	localparam int unsigned RC_W       = 9;
	localparam int unsigned SCNT_W     = 10;
	localparam int unsigned GCNT_W     = 8;
	localparam int unsigned RCNT_W     = 8;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;

	localparam logic [SPG_W-1:0] MAX_SAMPLES_PER_GROUP = 11'd1024;
	localparam logic [GPR_W-1:0] MAX_GROUPS_PER_REGION = 9'd256;
	localparam logic [RC_W-1:0]  MAX_REGIONS           = 9'd256;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SPG = 2'd0;
	localparam logic [1:0] REG_GPR = 2'd1;
	localparam logic [1:0] REG_RC  = 2'd2;

	// result levels
	localparam logic [LEVEL_W-1:0] LVL_LEAF   = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_REGION = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_TOTAL  = 2'd2;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level;
		logic [INDEX_W-1:0]  group_index;
		logic [SAMPLE_W-1:0] min_value;
		logic [SAMPLE_W-1:0] max_value;
		logic                last;
	} res_t;

endpackage

>>> rtl/hmmr_smp_if.sv
interface hmmr_smp_if import hmmr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/hmmr_res_if.sv
interface hmmr_res_if import hmmr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LEVEL_W-1:0]  level;
	logic [INDEX_W-1:0]  group_index;
	logic [SAMPLE_W-1:0] min_value;
	logic [SAMPLE_W-1:0] max_value;
	logic                last;

	modport source (output valid, output level, output group_index, output min_value,
		output max_value, output last, input ready);
	modport sink   (input valid, input level, input group_index, input min_value,
		input max_value, input last, output ready);
endinterface

>>> rtl/hierarchical_min_max_reduce.sv
// Flow: a sample accepted is registered in stage s1; its results are then written
//   into the output queue and shown on res in order from the queue head.
// Throughput: one sample per cycle while the queue has room and each sample yields
//   at most one result; a sample closing a region or the data set gives 2 or 3 results,
//   sent one per cycle while res is ready; the single result port then sets the rate.
// Reset (arst_n low, asynchronous): counters, running min/max and 8-entry output queue
//   emptied, all three count registers back to 1.
module hierarchical_min_max_reduce import hmmr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	hmmr_smp_if.sink           smp,
	hmmr_res_if.source         res
);

	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;
	// room for an item in s1 and one being accepted, three results each
	localparam logic [QCNT_W-1:0] QROOM = QCNT_W'(QDEPTH - 6);

	// configuration registers
	logic [SPG_W-1:0] spg_q;
	logic [GPR_W-1:0] gpr_q;
	logic [RC_W-1:0]  rc_q;

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// running state
	logic [SCNT_W-1:0]   scnt_q;
	logic [GCNT_W-1:0]   gcnt_q;
	logic [RCNT_W-1:0]   rcnt_q;
	logic [SAMPLE_W-1:0] gmin_q, gmax_q, rmin_q, rmax_q, tmin_q, tmax_q;

	// output queue
	res_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// ---------------- APB configuration ----------------
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spg_q <= SPG_W'(1);
			gpr_q <= GPR_W'(1);
			rc_q  <= RC_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SPG: spg_q <= pwdata[SPG_W-1:0];
				REG_GPR: gpr_q <= pwdata[GPR_W-1:0];
				REG_RC:  rc_q  <= pwdata[RC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SPG: prdata = DATA_W'(spg_q);
			REG_GPR: prdata = DATA_W'(gpr_q);
			REG_RC:  prdata = DATA_W'(rc_q);
			default: prdata = '0;
		endcase
	end

	// zero acts as one, values beyond the limit act as the limit
	logic [SPG_W-1:0] spg;
	logic [GPR_W-1:0] gpr;
	logic [RC_W-1:0]  rc;

	always_comb begin
		spg = (spg_q == '0) ? SPG_W'(1) : (spg_q > MAX_SAMPLES_PER_GROUP) ?
			MAX_SAMPLES_PER_GROUP : spg_q;
		gpr = (gpr_q == '0) ? GPR_W'(1) : (gpr_q > MAX_GROUPS_PER_REGION) ?
			MAX_GROUPS_PER_REGION : gpr_q;
		rc  = (rc_q == '0) ? RC_W'(1) : (rc_q > MAX_REGIONS) ? MAX_REGIONS : rc_q;
	end

	// ---------------- input register ----------------
	logic smp_acc;
	assign smp.ready = (cnt_q <= QROOM);
	assign smp_acc   = smp.valid & smp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= smp_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			sample_s1 <= smp.sample;
		end
	end

	// ---------------- min/max and group close logic ----------------
	logic                first_leaf, first_region, first_total;
	logic                leaf_close, region_close, total_close;
	logic [SAMPLE_W-1:0] gmin_n, gmax_n, rmin_n, rmax_n, tmin_n, tmax_n;
	logic [INDEX_W-1:0]  leaf_idx;
	logic [1:0]          nres;
	res_t                rslt [3];

	always_comb begin
		first_leaf   = (scnt_q == '0);
		first_region = first_leaf && (gcnt_q == '0);
		first_total  = first_region && (rcnt_q == '0);

		gmin_n = (first_leaf || sample_s1 < gmin_q) ? sample_s1 : gmin_q;
		gmax_n = (first_leaf || sample_s1 > gmax_q) ? sample_s1 : gmax_q;
		rmin_n = (first_region || sample_s1 < rmin_q) ? sample_s1 : rmin_q;
		rmax_n = (first_region || sample_s1 > rmax_q) ? sample_s1 : rmax_q;
		tmin_n = (first_total || sample_s1 < tmin_q) ? sample_s1 : tmin_q;
		tmax_n = (first_total || sample_s1 > tmax_q) ? sample_s1 : tmax_q;

		// a level closes once its counter reaches count - 1 (or passes it)
		leaf_close   = !(({1'b0, scnt_q} + SPG_W'(1)) < spg);
		region_close = leaf_close && !(({1'b0, gcnt_q} + GPR_W'(1)) < gpr);
		total_close  = region_close && !(({1'b0, rcnt_q} + RC_W'(1)) < rc);

		leaf_idx = INDEX_W'({8'b0, rcnt_q} * {7'b0, gpr}) + INDEX_W'(gcnt_q);

		rslt[0] = '{level: LVL_LEAF, group_index: leaf_idx, min_value: gmin_n,
			max_value: gmax_n, last: !region_close};
		rslt[1] = '{level: LVL_REGION, group_index: INDEX_W'(rcnt_q), min_value: rmin_n,
			max_value: rmax_n, last: !total_close};
		rslt[2] = '{level: LVL_TOTAL, group_index: '0, min_value: tmin_n,
			max_value: tmax_n, last: 1'b1};

		if (!valid_s1 || !leaf_close) begin
			nres = 2'd0;
		end else if (!region_close) begin
			nres = 2'd1;
		end else if (!total_close) begin
			nres = 2'd2;
		end else begin
			nres = 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
			gcnt_q <= '0;
			rcnt_q <= '0;
			gmin_q <= '0;
			gmax_q <= '0;
			rmin_q <= '0;
			rmax_q <= '0;
			tmin_q <= '0;
			tmax_q <= '0;
		end else if (valid_s1) begin
			gmin_q <= gmin_n;
			gmax_q <= gmax_n;
			rmin_q <= rmin_n;
			rmax_q <= rmax_n;
			tmin_q <= tmin_n;
			tmax_q <= tmax_n;
			if (!leaf_close) begin
				scnt_q <= scnt_q + SCNT_W'(1);
			end else begin
				scnt_q <= '0;
				if (!region_close) begin
					gcnt_q <= gcnt_q + GCNT_W'(1);
				end else begin
					gcnt_q <= '0;
					// end of the data set wraps everything to a fresh start
					rcnt_q <= total_close ? '0 : rcnt_q + RCNT_W'(1);
				end
			end
		end
	end

	// ---------------- output queue ----------------
	logic res_pop;
	assign res_pop   = res.valid & res.ready;
	assign res.valid = (cnt_q != '0);

	always_comb begin
		res.level       = queue_q[rd_ptr_q].level;
		res.group_index = queue_q[rd_ptr_q].group_index;
		res.min_value   = queue_q[rd_ptr_q].min_value;
		res.max_value   = queue_q[rd_ptr_q].max_value;
		res.last        = queue_q[rd_ptr_q].last;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < nres) begin
				queue_q[wr_ptr_q + QPTR_W'(k)] <= rslt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(nres);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(res_pop);
			cnt_q    <= cnt_q + QCNT_W'(nres) - QCNT_W'(res_pop);
		end
	end

endmodule
